@@ sv/ile_pkg.sv @@
`timescale 1ns / 1ps
package ile_pkg;

    localparam int DEF_DEPTH       = 32;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int IDX_W    = 8;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    typedef enum logic [2:0] {
        OP_INS = 3'd0,
        OP_DEL = 3'd1,
        OP_SET = 3'd2,
        OP_GET = 3'd3,
        OP_CLR = 3'd4
    } t_op;

    localparam logic [STATUS_W-1:0] STS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STS_BADIDX = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL   = 2'd2;

    typedef enum logic [2:0] {
        CELL_HOLD = 3'd0,
        CELL_INS  = 3'd1,
        CELL_DEL  = 3'd2,
        CELL_WR   = 3'd3,
        CELL_ZERO = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [IDX_W-1:0] idx;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_CLEAR = 2'b10
    } t_state;

endpackage

@@ sv/indexed_list_engine.sv @@
`timescale 1ns / 1ps
// Bounded list of up to DEPTH handles held in a chain of cells, one entry per cell; every cell
// that shifts moves to its neighbor in the same cycle, so insert, delete, set and get each load
// their result as the cells update, and the next item is accepted in the cycle after the result
// is loaded, as long as the result register is free or being drained. Clear on a non-empty list
// enters a clear state and then emits one result per entry from the last entry down, with tlast
// on the final one; input is held off until the last clear result is loaded. Results sit in a
// single output register, so a stalled output holds off new input.
module indexed_list_engine
    import ile_pkg::*;
#(
    parameter int DEPTH       = DEF_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // index[7:0], value[39:8]
    input  logic [2:0]  s_axis_tuser,  // op[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // status[1:0], read_value[33:2], entry_count[39:34],
                                       // released_valid[40], released_value[72:41], zero[79:73]
    output logic        m_axis_tlast   // last
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [VALUE_WIDTH-1:0] w_cell [DEPTH];
    logic [VALUE_WIDTH-1:0] w_taps [DEPTH];
    logic [VALUE_WIDTH-1:0] w_tap;
    logic [VALUE_WIDTH-1:0] w_value;
    logic [DATA_W-1:0]      w_tap32;
    t_cell_ctl              w_ctl;

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_used, n_used;
    logic                   r_valid;
    logic [STATUS_W-1:0]    r_status, n_status;
    logic [DATA_W-1:0]      r_rd, n_rd;
    logic [COUNT_W-1:0]     r_count;
    logic                   r_rel_valid;
    logic [DATA_W-1:0]      r_rel, n_rel;
    logic                   r_last, n_last;

    logic                   w_fire;
    logic                   w_free;
    logic                   w_load;
    logic [IDX_W-1:0]       w_index;
    logic [8:0]             w_idx9;
    logic [8:0]             w_used9;
    logic                   w_ins_inside;
    logic                   w_ins_full;
    t_op                    w_op;

    assign w_index = s_axis_tdata[7:0];
    assign w_value = VALUE_WIDTH'(s_axis_tdata[39:8]);
    assign w_op    = t_op'(s_axis_tuser);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [VALUE_WIDTH-1:0] w_prev;
            logic [VALUE_WIDTH-1:0] w_next;
            if (g == 0) begin : g_first
                assign w_prev = '0;
            end else begin : g_mid_lo
                assign w_prev = w_cell[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_next = '0;
            end else begin : g_mid_hi
                assign w_next = w_cell[g+1];
            end
            ile_cell #(
                .VALUE_WIDTH(VALUE_WIDTH)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_pos   (IDX_W'(g)),
                .i_ctl   (w_ctl),
                .i_value (w_value),
                .i_prev  (w_prev),
                .i_next  (w_next),
                .o_value (w_cell[g]),
                .o_tap   (w_taps[g])
            );
        end
    endgenerate

    always_comb begin
        w_tap = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_tap = w_tap | w_taps[k];
        end
    end

    assign w_tap32 = DATA_W'(w_tap);

    assign w_free        = !r_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && w_free;
    assign w_fire        = s_axis_tvalid && s_axis_tready;

    assign w_idx9       = {1'b0, w_index};
    assign w_used9      = 9'(r_used);
    assign w_ins_inside = (w_idx9 < w_used9);
    assign w_ins_full   = w_ins_inside ? (w_used9 >= 9'(DEPTH)) : (w_idx9 >= 9'(DEPTH));

    always_comb begin
        n_state  = r_state;
        n_used   = r_used;
        w_ctl.op = CELL_HOLD;
        w_ctl.idx = w_index;
        w_load   = 1'b0;
        n_status = STS_OK;
        n_rd     = '0;
        n_rel    = '0;
        n_last   = 1'b1;

        if (r_state == ST_CLEAR) begin
            w_ctl.idx = IDX_W'(r_used - CW'(1));
            if (w_free) begin
                w_ctl.op = CELL_ZERO;
                w_load   = 1'b1;
                n_rel    = w_tap32;
                n_used   = r_used - CW'(1);
                n_last   = (r_used == CW'(1));
                if (n_last) begin
                    n_state = ST_IDLE;
                end
            end
        end else if (w_fire) begin
            w_load = 1'b1;
            case (w_op)
                OP_INS: begin
                    if (w_ins_full) begin
                        n_status = STS_FULL;
                    end else if (w_ins_inside) begin
                        w_ctl.op = CELL_INS;
                        n_used   = r_used + CW'(1);
                    end else begin
                        w_ctl.op = CELL_WR;
                        n_used   = CW'(w_index) + CW'(1);
                    end
                end
                OP_DEL: begin
                    if (!w_ins_inside) begin
                        n_status = STS_BADIDX;
                    end else begin
                        w_ctl.op = CELL_DEL;
                        n_rel    = w_tap32;
                        n_used   = r_used - CW'(1);
                    end
                end
                OP_SET: begin
                    if (w_idx9 == w_used9) begin
                        if (w_ins_full) begin
                            n_status = STS_FULL;
                        end else begin
                            w_ctl.op = CELL_WR;
                            n_used   = CW'(w_index) + CW'(1);
                        end
                    end else if (!w_ins_inside) begin
                        n_status = STS_BADIDX;
                    end else begin
                        w_ctl.op = CELL_WR;
                        n_rel    = w_tap32;
                    end
                end
                OP_GET: begin
                    n_rd = w_tap32;
                end
                OP_CLR: begin
                    if (r_used != '0) begin
                        w_load  = 1'b0;
                        n_state = ST_CLEAR;
                    end
                end
                default: begin
                    n_status = STS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_used  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status    <= n_status;
            r_rd        <= n_rd;
            r_count     <= COUNT_W'(n_used);
            r_rel_valid <= (n_rel != '0);
            r_rel       <= n_rel;
            r_last      <= n_last;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {7'd0, r_rel, r_rel_valid, r_count, r_rd, r_status};
    assign m_axis_tlast  = r_last;

endmodule

@@ sv/ile_cell.sv @@
`timescale 1ns / 1ps
module ile_cell
    import ile_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [IDX_W-1:0]       i_pos,
    input  t_cell_ctl              i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic [VALUE_WIDTH-1:0] i_prev,
    input  logic [VALUE_WIDTH-1:0] i_next,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic [VALUE_WIDTH-1:0] o_tap
);

    logic [VALUE_WIDTH-1:0] r_val;
    logic [VALUE_WIDTH-1:0] n_val;
    logic                   w_hit;
    logic                   w_above;

    assign w_hit   = (i_pos == i_ctl.idx);
    assign w_above = (i_pos > i_ctl.idx);

    always_comb begin
        n_val = r_val;
        case (i_ctl.op)
            CELL_INS: begin
                if (w_above) begin
                    n_val = i_prev;
                end else if (w_hit) begin
                    n_val = i_value;
                end
            end
            CELL_DEL: begin
                if (w_above || w_hit) begin
                    n_val = i_next;
                end
            end
            CELL_WR: begin
                if (w_hit) begin
                    n_val = i_value;
                end
            end
            CELL_ZERO: begin
                if (w_hit) begin
                    n_val = '0;
                end
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else begin
            r_val <= n_val;
        end
    end

    assign o_value = r_val;
    assign o_tap   = w_hit ? r_val : '0;

endmodule

@@ sv/ile_check.sv @@
`timescale 1ns / 1ps
module ile_check
    import ile_pkg::*;
#(
    parameter int DEPTH = DEF_DEPTH
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata
);

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input ready while result stalled");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> {1'b0, m_axis_tdata[39:34]} <= 7'(DEPTH))
        else $error("entry count beyond depth");

    a_release_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[40] |-> m_axis_tdata[72:41] == 32'd0)
        else $error("released value without release flag");

    a_transfer_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid || !s_axis_tready)
        else $error("accepted item produced no result and no busy");

endmodule

bind indexed_list_engine ile_check #(.DEPTH(DEPTH)) u_ile_check (.*);
